FILE: rtl/gifipw_pkg.sv
package gifipw_pkg;

    localparam int unsigned DIM_W   = 12;
    localparam int unsigned OFS_W   = 11;
    localparam int unsigned PIX_W   = 8;
    localparam int unsigned ADDR_W  = 22;
    localparam int unsigned PASS_W  = 3;
    localparam int unsigned CFG_A_W = 3;
    localparam int unsigned CFG_D_W = 12;
    localparam int unsigned TDATA_W = 32;
    localparam int unsigned TUSER_W = 2;

    localparam logic [DIM_W-1:0] ROW_MAX = 12'd4095;

    // register map
    typedef enum logic [CFG_A_W-1:0] {
        CFG_SCREEN_WIDTH  = 3'd0,
        CFG_SCREEN_HEIGHT = 3'd1,
        CFG_IMAGE_LEFT    = 3'd2,
        CFG_IMAGE_TOP     = 3'd3,
        CFG_IMAGE_WIDTH   = 3'd4,
        CFG_INTERLACED    = 3'd5,
        CFG_TRANS_EN      = 3'd6,
        CFG_TRANS_INDEX   = 3'd7
    } t_cfg_idx;

    // interlace pass codes
    typedef enum logic [PASS_W-1:0] {
        PASS_SEQ = 3'd0,
        PASS_1   = 3'd1,
        PASS_2   = 3'd2,
        PASS_3   = 3'd3,
        PASS_4   = 3'd4
    } t_pass;

    // bit positions in the output tuser
    localparam int unsigned TUSER_WE  = 0;
    localparam int unsigned TUSER_OOR = 1;

endpackage

FILE: rtl/gif_interlace_pixel_writer_top.sv
// Channel   | Dir | Handshake                    | Payload
// s_axis    | in  | s_axis_tvalid/s_axis_tready  | tdata[7:0] pixel_index
// m_axis    | out | m_axis_tvalid/m_axis_tready  | tdata[21:0] write_address,
//           |     |                              | tdata[29:22] write_index,
//           |     |                              | tuser[0] write_enable,
//           |     |                              | tuser[1] out_of_range,
//           |     |                              | tlast row_done
// cfg       | in  | i_cfg_we (no wait)           | i_cfg_addr, i_cfg_wdata
//
// One item per cycle unless m_axis stalls; stage 1 and stage 2 are registered.
// Stage 1 walks the raster (row/pass/column) at accept; stage 2 forms
// row * screen_width + left + column through one 12x12 multiply-add.
// Reset (synchronous, active low) and any config write restart the image at its origin.
// A stall on m_axis backs up into stage 1; s_axis_tready drops only when both are full.
module gif_interlace_pixel_writer_top
    import gifipw_pkg::*;
#(
    parameter int unsigned MAX_DIM = 2048
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // config write port
    input  logic               i_cfg_we,
    input  logic [CFG_A_W-1:0] i_cfg_addr,
    input  logic [CFG_D_W-1:0] i_cfg_wdata,
    // pixel in
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [PIX_W-1:0]   s_axis_tdata,   // [7:0] pixel_index
    // write request out
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [TDATA_W-1:0] m_axis_tdata,   // [21:0] write_address, [29:22] write_index
    output logic [TUSER_W-1:0] m_axis_tuser,   // [0] write_enable, [1] out_of_range
    output logic               m_axis_tlast    // row_done
);

    // configuration
    logic [DIM_W-1:0] r_scr_w, r_scr_h, r_img_w;
    logic [OFS_W-1:0] r_img_left, r_img_top;
    logic             r_intl, r_trans_en;
    logic [PIX_W-1:0] r_trans_idx;

    // raster walk state
    logic [DIM_W-1:0] r_pix_left, n_pix_left;
    logic [DIM_W-1:0] r_row, n_row;
    logic [DIM_W-1:0] r_col, n_col;
    t_pass            r_pass, n_pass;

    // stage 1
    logic             r_s1_valid;
    logic [DIM_W-1:0] r_s1_row, r_s1_col;
    logic [PIX_W-1:0] r_s1_pix;
    logic             r_s1_we, r_s1_last, r_s1_oor;

    // stage 2 (output)
    logic              r_out_valid;
    logic [ADDR_W-1:0] r_out_addr;
    logic [PIX_W-1:0]  r_out_pix;
    logic              r_out_we, r_out_last, r_out_oor;

    logic               out_adv, in_acc;
    logic               cfg_hit;
    logic [DIM_W-1:0]   cfg_dim;
    logic               oor, row_end, transp;
    logic [DIM_W:0]     step_row;
    logic [2*DIM_W-1:0] s2_prod;
    logic [ADDR_W-1:0]  s2_addr;

    assign out_adv       = !r_out_valid || m_axis_tready;
    assign s_axis_tready = !r_s1_valid || out_adv;
    assign in_acc        = s_axis_tvalid && s_axis_tready;

    // oversized dimensions saturate
    assign cfg_dim = ({20'd0, i_cfg_wdata} > 32'(MAX_DIM)) ? DIM_W'(MAX_DIM) : i_cfg_wdata;

    always_comb begin
        cfg_hit = 1'b0;
        unique case (t_cfg_idx'(i_cfg_addr))
            CFG_SCREEN_WIDTH, CFG_SCREEN_HEIGHT, CFG_IMAGE_LEFT, CFG_IMAGE_TOP,
            CFG_IMAGE_WIDTH, CFG_INTERLACED, CFG_TRANS_EN, CFG_TRANS_INDEX: cfg_hit = i_cfg_we;
            default: cfg_hit = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scr_w     <= 12'd320;
            r_scr_h     <= 12'd200;
            r_img_left  <= '0;
            r_img_top   <= '0;
            r_img_w     <= 12'd320;
            r_intl      <= 1'b0;
            r_trans_en  <= 1'b0;
            r_trans_idx <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_addr))
                CFG_SCREEN_WIDTH:  r_scr_w     <= cfg_dim;
                CFG_SCREEN_HEIGHT: r_scr_h     <= cfg_dim;
                CFG_IMAGE_LEFT:    r_img_left  <= i_cfg_wdata[OFS_W-1:0];
                CFG_IMAGE_TOP:     r_img_top   <= i_cfg_wdata[OFS_W-1:0];
                CFG_IMAGE_WIDTH:   r_img_w     <= cfg_dim;
                CFG_INTERLACED:    r_intl      <= i_cfg_wdata[0];
                CFG_TRANS_EN:      r_trans_en  <= i_cfg_wdata[0];
                CFG_TRANS_INDEX:   r_trans_idx <= i_cfg_wdata[PIX_W-1:0];
                default: ;
            endcase
        end
    end

    // per-pixel classification from the current raster position
    assign oor     = r_row >= r_scr_h;
    assign transp  = r_trans_en && (s_axis_tdata == r_trans_idx);
    assign row_end = r_pix_left <= 12'd1;

    // next row and pass after a row ends
    always_comb begin
        n_pass   = r_pass;
        step_row = {1'b0, r_row} + 13'd1;
        case (r_pass)
            PASS_1: begin
                step_row = {1'b0, r_row} + 13'd8;
                if (step_row >= {1'b0, r_scr_h}) begin
                    n_pass   = PASS_2;
                    step_row = {2'b00, r_img_top} + 13'd4;
                end
            end
            PASS_2: begin
                step_row = {1'b0, r_row} + 13'd8;
                if (step_row >= {1'b0, r_scr_h}) begin
                    n_pass   = PASS_3;
                    step_row = {2'b00, r_img_top} + 13'd2;
                end
            end
            PASS_3: begin
                step_row = {1'b0, r_row} + 13'd4;
                if (step_row >= {1'b0, r_scr_h}) begin
                    n_pass   = PASS_4;
                    step_row = {2'b00, r_img_top} + 13'd1;
                end
            end
            PASS_4:  step_row = {1'b0, r_row} + 13'd2;
            default: step_row = {1'b0, r_row} + 13'd1;
        endcase
    end

    always_comb begin
        n_pix_left = r_pix_left;
        n_row      = r_row;
        n_col      = r_col;
        if (row_end) begin
            n_pix_left = r_img_w;
            n_col      = '0;
            // row counter saturates, never in range after that
            n_row      = step_row[DIM_W] ? ROW_MAX : step_row[DIM_W-1:0];
        end else begin
            n_pix_left = r_pix_left - 12'd1;
            n_col      = r_col + 12'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pix_left <= 12'd320;
            r_row      <= '0;
            r_col      <= '0;
            r_pass     <= PASS_SEQ;
        end else if (cfg_hit) begin
            // restart at the image origin with the value just written
            r_col <= '0;
            r_pix_left <= (t_cfg_idx'(i_cfg_addr) == CFG_IMAGE_WIDTH) ? cfg_dim : r_img_w;
            r_row <= {1'b0, (t_cfg_idx'(i_cfg_addr) == CFG_IMAGE_TOP)
                            ? i_cfg_wdata[OFS_W-1:0] : r_img_top};
            if (t_cfg_idx'(i_cfg_addr) == CFG_INTERLACED) begin
                r_pass <= i_cfg_wdata[0] ? PASS_1 : PASS_SEQ;
            end else begin
                r_pass <= r_intl ? PASS_1 : PASS_SEQ;
            end
        end else if (in_acc) begin
            r_pix_left <= n_pix_left;
            r_row      <= n_row;
            r_col      <= n_col;
            if (row_end) begin
                r_pass <= n_pass;
            end
        end
    end

    // stage 1: item plus its raster position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_s1_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_row  <= r_row;
            r_s1_col  <= r_col;
            r_s1_pix  <= s_axis_tdata;
            r_s1_we   <= !transp && !oor;
            r_s1_last <= row_end;
            r_s1_oor  <= oor;
        end
    end

    // stage 2: row * pitch + left + column, wraps at the address width
    assign s2_prod = r_s1_row * r_scr_w;
    assign s2_addr = s2_prod[ADDR_W-1:0] + ADDR_W'(r_img_left) + ADDR_W'(r_s1_col);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_adv) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_adv && r_s1_valid) begin
            r_out_addr <= s2_addr;
            r_out_pix  <= r_s1_pix;
            r_out_we   <= r_s1_we;
            r_out_last <= r_s1_last;
            r_out_oor  <= r_s1_oor;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {2'b00, r_out_pix, r_out_addr};
    assign m_axis_tuser  = {r_out_oor, r_out_we};
    assign m_axis_tlast  = r_out_last;

endmodule

FILE: rtl/gifipw_checker.sv
module gifipw_checker
    import gifipw_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_cfg_we,
    input logic               m_axis_tvalid,
    input logic               m_axis_tready,
    input logic [TDATA_W-1:0] m_axis_tdata,
    input logic [TUSER_W-1:0] m_axis_tuser,
    input logic               m_axis_tlast
);

    // nothing comes out right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid right after reset");

    // a stalled item holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
            && $stable(m_axis_tlast))
        else $error("stalled item changed");

    // a row beyond the screen is never written
    a_no_oor_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !(m_axis_tuser[TUSER_WE] && m_axis_tuser[TUSER_OOR]))
        else $error("write issued beyond screen");

    // within a row, back-to-back items step the address by one
    a_addr_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tready && !m_axis_tlast && !i_cfg_we
        ##1 m_axis_tvalid && $past(m_axis_tvalid) |->
            m_axis_tdata[ADDR_W-1:0] == ADDR_W'($past(m_axis_tdata[ADDR_W-1:0]) + 22'd1))
        else $error("address did not advance by one inside a row");

    // pad bits stay zero
    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[TDATA_W-1:ADDR_W+PIX_W] == '0)
        else $error("tdata pad bits set");

endmodule

bind gif_interlace_pixel_writer_top gifipw_checker u_gifipw_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_cfg_we      (i_cfg_we),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

FILE: tb/sv/gif_interlace_pixel_writer_top_test.sv
`timescale 1ns / 1ps

module gif_interlace_pixel_writer_top_test;
    import gifipw_pkg::*;

    localparam int unsigned DIM_LIMIT    = 2048;
    localparam int unsigned RANDOM_ITEMS = 60;
    // enough pixels for pass 4 to walk from row 2048 up to the row ceiling
    localparam int unsigned CEILING_RUN  = 1032;

    // one value per register, in register index order
    typedef logic [CFG_D_W-1:0] reg_image_t [8];

    // one frame buffer write request as the block should emit it
    typedef struct {
        logic              we;
        logic [ADDR_W-1:0] addr;
        logic [PIX_W-1:0]  index;
        logic              row_done;
        logic              oor;
    } pixel_write_t;

    // Tracks the raster walk (column, row, interlace pass, address) for every
    // accepted pixel and holds the write requests that must come out, in order.
    class raster_tracker;
        logic [DIM_W-1:0]  scr_w, scr_h, img_w;
        logic [OFS_W-1:0]  img_left, img_top;
        logic              ilace, trans_en;
        logic [PIX_W-1:0]  trans_idx;

        logic [DIM_W-1:0]  px_left;
        logic [DIM_W-1:0]  row;
        t_pass             pass_code;
        logic [ADDR_W-1:0] addr;

        pixel_write_t expected_writes[$];
        int unsigned  mismatches, checked, pixels, rows, oor_rows, skipped;

        function new();
            scr_w     = 12'd320;
            scr_h     = 12'd200;
            img_left  = '0;
            img_top   = '0;
            img_w     = 12'd320;
            ilace     = 1'b0;
            trans_en  = 1'b0;
            trans_idx = '0;
            rewind();
        endfunction

        function logic [ADDR_W-1:0] row_base(logic [DIM_W-1:0] r);
            logic [31:0] sum;
            sum = 32'(r) * 32'(scr_w) + 32'(img_left);
            return sum[ADDR_W-1:0];
        endfunction

        function logic [DIM_W-1:0] clamp_dim(logic [CFG_D_W-1:0] v);
            return (v > CFG_D_W'(DIM_LIMIT)) ? DIM_W'(DIM_LIMIT) : v;
        endfunction

        // back to the image origin
        function void rewind();
            px_left   = img_w;
            row       = DIM_W'(img_top);
            pass_code = ilace ? PASS_1 : PASS_SEQ;
            addr      = row_base(row);
        endfunction

        function void apply_reg(t_cfg_idx idx, logic [CFG_D_W-1:0] v);
            case (idx)
                CFG_SCREEN_WIDTH:  scr_w     = clamp_dim(v);
                CFG_SCREEN_HEIGHT: scr_h     = clamp_dim(v);
                CFG_IMAGE_LEFT:    img_left  = v[OFS_W-1:0];
                CFG_IMAGE_TOP:     img_top   = v[OFS_W-1:0];
                CFG_IMAGE_WIDTH:   img_w     = clamp_dim(v);
                CFG_INTERLACED:    ilace     = v[0];
                CFG_TRANS_EN:      trans_en  = v[0];
                CFG_TRANS_INDEX:   trans_idx = v[PIX_W-1:0];
                default: ;
            endcase
            rewind();
        endfunction

        function void note_pixel(logic [PIX_W-1:0] pix);
            pixel_write_t w;
            logic         clear;
            int unsigned  nxt;
            w.oor      = row >= scr_h;
            clear      = trans_en && pix == trans_idx;
            w.we       = !clear && !w.oor;
            w.addr     = addr;
            w.index    = pix;
            w.row_done = px_left <= 1;
            expected_writes.push_back(w);
            pixels++;
            if (w.oor) oor_rows++;
            if (clear && !w.oor) skipped++;

            if (w.row_done) begin
                rows++;
                nxt     = row;
                px_left = img_w;
                case (pass_code)
                    PASS_1: begin
                        nxt += 8;
                        if (nxt >= scr_h) begin
                            pass_code = PASS_2;
                            nxt       = img_top + 4;
                        end
                    end
                    PASS_2: begin
                        nxt += 8;
                        if (nxt >= scr_h) begin
                            pass_code = PASS_3;
                            nxt       = img_top + 2;
                        end
                    end
                    PASS_3: begin
                        nxt += 4;
                        if (nxt >= scr_h) begin
                            pass_code = PASS_4;
                            nxt       = img_top + 1;
                        end
                    end
                    PASS_4:  nxt += 2;   // last pass never ends
                    default: nxt += 1;
                endcase
                row  = (nxt > ROW_MAX) ? ROW_MAX : nxt[DIM_W-1:0];
                addr = row_base(row);
            end else begin
                px_left = px_left - 1'b1;
                addr    = addr + 1'b1;
            end
        endfunction

        function void compare(string field, int unsigned want, int unsigned got);
            if (want != got) begin
                $error("%s: expected %0h, got %0h", field, want, got);
                mismatches++;
            end
        endfunction

        function void check_write(logic [TDATA_W-1:0] data, logic [TUSER_W-1:0] flags,
                                  logic last);
            pixel_write_t want;
            if (expected_writes.size() == 0) begin
                $error("write request with none pending: tdata %h tuser %b", data, flags);
                mismatches++;
                return;
            end
            want = expected_writes.pop_front();
            checked++;
            compare("write_enable", want.we, flags[TUSER_WE]);
            compare("write_address", want.addr, data[ADDR_W-1:0]);
            compare("write_index", want.index, data[ADDR_W +: PIX_W]);
            compare("row_done", want.row_done, last);
            compare("out_of_range", want.oor, flags[TUSER_OOR]);
        endfunction
    endclass

    // ---------------------------------------------------------------------
    // clock, DUT ports, DUT
    // ---------------------------------------------------------------------
    logic i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    logic               i_rst_n;
    logic               i_cfg_we;
    logic [CFG_A_W-1:0] i_cfg_addr;
    logic [CFG_D_W-1:0] i_cfg_wdata;
    logic               s_axis_tvalid;
    logic               s_axis_tready;
    logic [PIX_W-1:0]   s_axis_tdata;    // [7:0] pixel_index
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    logic [TDATA_W-1:0] m_axis_tdata;    // [21:0] write_address, [29:22] write_index
    logic [TUSER_W-1:0] m_axis_tuser;    // [0] write_enable, [1] out_of_range
    logic               m_axis_tlast;    // row_done

    gif_interlace_pixel_writer_top #(
        .MAX_DIM (DIM_LIMIT)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    raster_tracker tracker = new();

    // calm = no idle cycles on that side for the current phase
    logic        src_calm  = 1'b0;
    logic        sink_calm = 1'b0;
    int unsigned sink_gap;
    int unsigned sink_hold;
    int unsigned setups_loaded = 0;

    // ---------------------------------------------------------------------
    // write request sink: checks each accepted item, then may hold tready
    // low before taking the next one
    // ---------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            sink_gap      <= 0;
        end else if (m_axis_tready) begin
            if (m_axis_tvalid) begin
                tracker.check_write(m_axis_tdata, m_axis_tuser, m_axis_tlast);
                sink_hold = sink_calm ? 0 : $urandom_range(0, 3);
                if (sink_hold != 0) begin
                    m_axis_tready <= 1'b0;
                    sink_gap      <= sink_hold - 1;
                end
            end
        end else if (sink_gap == 0) begin
            m_axis_tready <= 1'b1;
        end else begin
            sink_gap <= sink_gap - 1;
        end
    end

    // hard stop in case the block hangs
    initial begin
        #5_000_000;
        $display("end of test: mismatches");
        $finish;
    end

    // ---------------------------------------------------------------------
    // driver tasks; each is entered right after a rising edge
    // ---------------------------------------------------------------------

    // one register write; the caller drops i_cfg_we after the last one
    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_D_W-1:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        tracker.apply_reg(idx, value);
    endtask

    task automatic load_setup(input reg_image_t regs);
        for (int k = 0; k < 8; k++) begin
            write_reg(t_cfg_idx'(k), regs[k]);
        end
        i_cfg_we <= 1'b0;
        setups_loaded++;
    endtask

    task automatic send_pixel(input logic [PIX_W-1:0] pix);
        int unsigned gap;
        gap = src_calm ? 0 : $urandom_range(0, 3);
        repeat (gap) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= pix;
        do @(posedge i_clk); while (!s_axis_tready);
        tracker.note_pixel(pix);
    endtask

    // sender stops and waits until every pending write request is out
    task automatic drain_writes();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (tracker.expected_writes.size() != 0) @(posedge i_clk);
    endtask

    // idle point for register writes: drained plus pipeline flush margin
    task automatic settle();
        drain_writes();
        repeat (4) @(posedge i_clk);
    endtask

    // transparent index a quarter of the time when transparency is on
    function automatic logic [PIX_W-1:0] pick_pixel();
        if (tracker.trans_en && $urandom_range(0, 3) == 0) return tracker.trans_idx;
        return PIX_W'($urandom);
    endfunction

    // mostly small dimensions so rows and passes turn over often
    function automatic logic [CFG_D_W-1:0] pick_dim(input int unsigned typical);
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return CFG_D_W'($urandom);      // may exceed the cap
            2:       return CFG_D_W'(DIM_LIMIT);
            default: return CFG_D_W'($urandom_range(1, typical));
        endcase
    endfunction

    function automatic reg_image_t random_setup();
        reg_image_t s;
        s[CFG_SCREEN_WIDTH]  = pick_dim(64);
        s[CFG_SCREEN_HEIGHT] = pick_dim(40);
        s[CFG_IMAGE_LEFT]    = CFG_D_W'($urandom);   // upper bit is dropped
        s[CFG_IMAGE_TOP]     = ($urandom_range(0, 3) == 0) ? CFG_D_W'($urandom)
                                                            : CFG_D_W'($urandom_range(0, 9));
        s[CFG_IMAGE_WIDTH]   = pick_dim(12);
        s[CFG_INTERLACED]    = CFG_D_W'($urandom);   // only bit 0 counts
        s[CFG_TRANS_EN]      = CFG_D_W'($urandom);
        s[CFG_TRANS_INDEX]   = CFG_D_W'($urandom);
        return s;
    endfunction

    // ---------------------------------------------------------------------
    // stimulus
    // ---------------------------------------------------------------------
    initial begin
        reg_image_t  setup;
        int unsigned random_sent;
        int unsigned run_len;
        t_cfg_idx    one_reg;

        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_addr    = '0;
        i_cfg_wdata   = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset defaults: 320x200 screen, sequential, no transparency
        send_pixel(8'hFF);
        send_pixel(8'h00);
        send_pixel(8'h5A);
        settle();

        // oversized dims saturate; far corner hits the top address, then wraps;
        // next row lands on the screen height and is suppressed
        setup = '{12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 12'd2, 12'd0, 12'd1, 12'h03C};
        load_setup(setup);
        send_pixel(8'h3C);
        send_pixel(8'h3D);
        send_pixel(8'hC3);
        send_pixel(8'h3C);
        settle();

        // zero image width: every pixel ends a row; tiny screen runs all passes
        setup = '{12'd8, 12'd3, 12'd0, 12'd0, 12'd0, 12'd1, 12'd0, 12'd0};
        load_setup(setup);
        repeat (7) send_pixel(PIX_W'($urandom));
        settle();

        // one-pixel rows through the full interlace order on a 20-row screen
        setup = '{12'd16, 12'd20, 12'd5, 12'd0, 12'd1, 12'd1, 12'd1, 12'h0FF};
        load_setup(setup);
        for (int k = 0; k < 11; k++) begin
            send_pixel(k[0] ? 8'hFF : PIX_W'($urandom));
        end
        settle();

        // random phases: a fresh setup or a single register poke, then a burst
        random_sent = 0;
        while (random_sent < RANDOM_ITEMS) begin
            setup = random_setup();
            if ($urandom_range(0, 2) == 0) begin
                one_reg = t_cfg_idx'($urandom_range(0, 7));
                write_reg(one_reg, setup[one_reg]);
                i_cfg_we <= 1'b0;
            end else begin
                load_setup(setup);
            end
            src_calm  = ($urandom_range(0, 3) == 0);
            sink_calm = ($urandom_range(0, 3) == 0);
            run_len   = $urandom_range(10, 30);
            repeat (run_len) begin
                send_pixel(pick_pixel());
                random_sent++;
                if ($urandom_range(0, 63) == 0) drain_writes();
            end
            settle();
        end

        // last-row image origin with zero width: pass 4 climbs two rows
        // per pixel until the row counter pins at its ceiling, addresses wrap
        src_calm  = 1'b0;
        sink_calm = 1'b0;
        setup = '{12'd2048, 12'hFFF, CFG_D_W'($urandom), 12'd2047, 12'd0, 12'd1,
                  12'd0, 12'd0};
        load_setup(setup);
        repeat (CEILING_RUN) send_pixel(PIX_W'($urandom));

        drain_writes();
        repeat (8) @(posedge i_clk);

        $display("ran %0d pixels across %0d full register setups; %0d write requests checked",
                 tracker.pixels, setups_loaded, tracker.checked);
        $display("%0d rows finished, %0d pixels on rows past the screen, %0d transparent skips",
                 tracker.rows, tracker.oor_rows, tracker.skipped);
        if (tracker.mismatches == 0 && tracker.expected_writes.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
